// ===== src/cfr_pkg.sv =====
`timescale 1ns / 1ps

package cfr_pkg;

   // Frame delimiters and checksum digit base
   localparam logic [7:0] CH_START = 8'h23;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_BASE  = 8'h3D;

   localparam int DEFAULT_BUFFER_DEPTH = 32;

   localparam int LEN_W  = 6;
   localparam int BYTE_W = 8;
   localparam int SUM_W  = 12;

   localparam logic [1:0] OP_BYTE    = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;
   localparam logic [1:0] OP_NOP     = 2'd3;

   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_ACCEPT = 2'd1;
   localparam logic [1:0] EV_REJECT = 2'd2;
   localparam logic [1:0] EV_DROP   = 2'd3;

   typedef struct packed {
      logic [1:0]        operation;
      logic [BYTE_W-1:0] rx_data;
      logic [LEN_W-1:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0]  frame_length;
      logic [BYTE_W-1:0] frame_label;
      logic [BYTE_W-1:0] read_data;
      logic [1:0]        frame_event;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [LEN_W-1:0]  addr;
      logic [BYTE_W-1:0] data;
   } store_wr_type;

endpackage

// ===== src/cfr_ram.sv =====
`timescale 1ns / 1ps

module cfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 33,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cfr_assembler.sv =====
`timescale 1ns / 1ps

module cfr_assembler
   import cfr_pkg::*;
#(
   parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  req_type            req,
   output logic [LEN_W-1:0]   held_length,
   output logic [BYTE_W-1:0]  label,
   output logic [1:0]         frame_event,
   output logic               rd_hit,
   output store_wr_type       store_wr
);

   localparam int PW = $clog2(BUFFER_DEPTH + 1);

   logic [PW-1:0]     pos_ff, pos_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [LEN_W-1:0]  held_ff, held_in;
   logic [BYTE_W-1:0] prev1_ff, prev1_in;
   logic [BYTE_W-1:0] prev2_ff, prev2_in;
   logic [BYTE_W-1:0] label_ff, label_in;

   logic [SUM_W-1:0]  body_sum;
   logic [BYTE_W-1:0] digit_hi, digit_lo;
   logic              sum_ok;
   logic [BYTE_W-1:0] b;

   assign b = req.rx_data;

   // Sum of the frame without its two checksum bytes
   always_comb begin
      body_sum = sum_ff - SUM_W'(prev2_ff) - SUM_W'(prev1_ff);
      digit_hi = CH_BASE + BYTE_W'(body_sum[SUM_W-1:6]);
      digit_lo = CH_BASE + BYTE_W'(body_sum[5:0]);
      sum_ok   = (digit_hi == prev2_ff) && (digit_lo == prev1_ff);
   end

   always_comb begin
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      held_in     = held_ff;
      prev1_in    = prev1_ff;
      prev2_in    = prev2_ff;
      label_in    = label_ff;
      frame_event = EV_NONE;
      rd_hit      = 1'b0;
      store_wr    = '0;

      unique case (req.operation)
         OP_BYTE: begin
            if (held_ff != '0) begin
               // hold: ignore bytes until release
            end else if (pos_ff == '0) begin
               if (b == CH_START) begin
                  store_wr = '{en: 1'b1, addr: '0, data: b};
                  pos_in   = PW'(1);
                  sum_in   = SUM_W'(b);
                  prev1_in = b;
               end
            end else if (b != CH_CR) begin
               if (pos_ff < PW'(BUFFER_DEPTH)) begin
                  store_wr = '{en: 1'b1, addr: LEN_W'(pos_ff), data: b};
                  pos_in   = pos_ff + PW'(1);
                  sum_in   = sum_ff + SUM_W'(b);
                  prev2_in = prev1_ff;
                  prev1_in = b;
                  if (pos_ff == PW'(1)) begin
                     label_in = b;
                  end
               end else begin
                  pos_in      = '0;
                  frame_event = EV_DROP;
               end
            end else begin
               pos_in = '0;
               if (pos_ff >= PW'(3) && sum_ok) begin
                  store_wr    = '{en: 1'b1, addr: LEN_W'(pos_ff), data: CH_CR};
                  held_in     = LEN_W'(pos_ff) + LEN_W'(1);
                  frame_event = EV_ACCEPT;
               end else begin
                  frame_event = EV_REJECT;
               end
            end
         end
         OP_RELEASE: begin
            held_in = '0;
         end
         OP_READ: begin
            rd_hit = (req.read_index < held_ff);
         end
         OP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         sum_ff  <= '0;
         held_ff <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prev1_ff <= prev1_in;
         prev2_ff <= prev2_in;
         label_ff <= label_in;
      end
   end

   assign held_length = held_ff;
   assign label       = (held_ff != '0) ? label_ff : '0;

endmodule

// ===== src/checksummed_frame_receiver.sv =====
`timescale 1ns / 1ps

// Checksummed frame receiver: assembles '#'...CR frames from received serial
// bytes, checks the two trailing base-64 sum digits, and holds a good frame
// (CR appended) until a release beat. Every request beat yields exactly one
// response beat carrying the held frame's length and label, the buffer byte
// for a read, and the frame event. Throughput is one beat per cycle but
// a stalled response stalls the request side in the same cycle. The response
// appears in the cycle after the request is taken, set by the single
// response register and the registered read port of the frame buffer RAM.
module checksummed_frame_receiver
   import cfr_pkg::*;
#(
   parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int STORE_DEPTH = BUFFER_DEPTH + 1;
   localparam int AW = $clog2(STORE_DEPTH);

   logic              accept;
   logic [LEN_W-1:0]  held_length;
   logic [BYTE_W-1:0] label;
   logic [1:0]        frame_event;
   logic              rd_hit;
   store_wr_type      store_wr;
   logic [BYTE_W-1:0] ram_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        event_ff;
   logic              rd_hit_ff;

   // Take a beat unless a finished response is still waiting
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   cfr_assembler #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_assembler (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_payload),
      .held_length (held_length),
      .label       (label),
      .frame_event (frame_event),
      .rd_hit      (rd_hit),
      .store_wr    (store_wr)
   );

   // Frame buffer; the read is launched with the request beat and its data
   // lands together with the response register.
   cfr_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && store_wr.en),
      .wr_addr (store_wr.addr[AW-1:0]),
      .wr_data (store_wr.data),
      .rd_en   (accept && rd_hit),
      .rd_addr (req_payload.read_index[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Advance the response register on accept, hold it while stalled
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff  <= frame_event;
         rd_hit_ff <= rd_hit;
      end
   end

   // Length and label come straight from state: it cannot change while the
   // response waits, since no request beat is taken then.
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_payload.frame_length = held_length;
   assign rsp_payload.frame_label  = label;
   assign rsp_payload.read_data    = rd_hit_ff ? ram_rd_data : '0;
   assign rsp_payload.frame_event  = event_ff;

endmodule
